FILE: rtl/core/hdu_pkg.sv
// Shared types, constants and helper functions of the haversine distance unit.
// Holds the fixed-point formats, the CORDIC arctangent table and the square-root step.
// Depends on nothing; every other file in rtl/core imports it.
package hdu_pkg;

  // Default number of CORDIC iterations.
  localparam int CORDIC_STAGES_DEF = 24;

  // Port field widths.
  localparam int LAT_W    = 28;
  localparam int LON_W    = 29;
  localparam int RADIUS_W = 13;
  localparam int DIST_W   = 23;

  // Radius after reset, in kilometres.
  localparam logic [RADIUS_W-1:0] RADIUS_RST = 13'd6371;

  // Angle in degrees Q21, signed, as fed to the sine/cosine unit.
  localparam int ANG_W = 30;
  // Sine, cosine and their products, Q30 signed.
  localparam int TRIG_W = 32;
  // CORDIC datapath width, Q30 signed with headroom.
  localparam int CW = 33;
  // Squared terms and products after the Q30 shift.
  localparam int PW = 32;
  // Haversine value a, Q30 unsigned in [0, 1].
  localparam int HV_W = 31;
  // Square-root result and remainder widths.
  localparam int ROOT_W = 31;
  localparam int SQ_W   = 62;
  // Central angle, Q30 radians, unsigned.
  localparam int ANGLE_W = 31;

  // Degree constants in Q21.
  localparam logic signed [ANG_W:0] DEG_FULL    = 31'sd754974720;
  localparam logic signed [ANG_W:0] DEG_HALF    = 31'sd377487360;
  localparam logic signed [ANG_W:0] DEG_QUARTER = 31'sd188743680;

  // Degree to radian conversion: round(mag * (pi/4) / (45 * 2^21)).
  localparam int MAG_W    = 28;
  localparam int PI4_W    = 30;
  localparam int PROD_W   = MAG_W + PI4_W;
  localparam int DEG_FRAC = 21;
  localparam logic [PI4_W-1:0]  PI4_Q30  = 30'h3243F6A8;
  localparam logic [PROD_W-1:0] RND_HALF = PROD_W'(45 * (2 ** 20));

  // Long division by 45, a group of quotient bits per stage.
  localparam int DIV_BITS = 8;
  localparam int DIV_ST   = 5;
  localparam int DIV_W    = DIV_BITS * DIV_ST;
  localparam int REM_W    = 6;
  localparam logic [REM_W:0] DIV_BASE = 7'd45;

  // CORDIC constants.
  localparam logic signed [CW-1:0] CORDIC_GAIN = 33'sd652032874;
  localparam logic signed [CW-1:0] ONE_Q30     = 33'sd1073741824;
  localparam logic [SQ_W-1:0]      ONE_Q60     = 62'h1000000000000000;

  // Arctangent of 2^-i in Q30 radians.
  localparam logic [30:0] ATAN_TAB [32] = '{
    31'h3243F6A8, 31'h1DAC6705, 31'h0FADBAFC, 31'h07F56EA6, 31'h03FEAB76, 31'h01FFD55B,
    31'h00FFFAAA, 31'h007FFF55, 31'h003FFFEA, 31'h001FFFFD, 31'h000FFFFF, 31'h0007FFFF,
    31'h0003FFFF, 31'h0001FFFF, 31'h0000FFFF, 31'h00007FFF, 31'h00003FFF, 31'h00001FFF,
    31'h00000FFF, 31'h000007FF, 31'h000003FF, 31'h000001FF, 31'h000000FF, 31'h0000007F,
    31'h0000003F, 31'h0000001F, 31'h0000000F, 31'h00000008, 31'h00000004, 31'h00000002,
    31'h00000001, 31'h00000000
  };

  // Partial square root: remainder of the radicand and the root found so far.
  typedef struct packed {
    logic [SQ_W-1:0]   rem;
    logic [ROOT_W-1:0] root;
  } sqrt_t;

  // One restoring square-root step that decides root bit k.
  function automatic sqrt_t sqrt_step(sqrt_t s, int k);
    logic [SQ_W-1:0] trial;
    sqrt_t           o;
    trial = (SQ_W'(s.root) << (k + 1)) | (SQ_W'(1) << (2 * k));
    o     = s;
    if (s.rem >= trial) begin
      o.rem  = s.rem - trial;
      o.root = s.root | (ROOT_W'(1) << k);
    end
    return o;
  endfunction

  // Limit a CORDIC output to [-1, 1] in Q30.
  function automatic logic signed [TRIG_W-1:0] clamp_unit(logic signed [CW-1:0] v);
    logic signed [TRIG_W-1:0] r;
    if (v > ONE_Q30) begin
      r = TRIG_W'(ONE_Q30);
    end else if (v < -ONE_Q30) begin
      r = -TRIG_W'(ONE_Q30);
    end else begin
      r = TRIG_W'(v);
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/hdu_sincos.sv
// Pipelined sine and cosine of an angle in degrees Q21, results in Q30.
// Wraps and folds the angle, converts to radians, then runs a rotation CORDIC.
// Depends on hdu_pkg.
module hdu_sincos
  import hdu_pkg::*;
#(
  parameter int STAGES = CORDIC_STAGES_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     vld_i,
  input  logic signed [ANG_W-1:0]  ang_i,
  output logic                     vld_o,
  output logic signed [TRIG_W-1:0] sin_o,
  output logic signed [TRIG_W-1:0] cos_o
);

  // Wrap the angle into [-180, 180) degrees.
  logic signed [ANG_W:0] ang_ext;
  logic signed [ANG_W:0] red_nxt;
  logic signed [ANG_W:0] red_r;
  logic                  v1_r;

  assign ang_ext = (ANG_W + 1)'(ang_i);

  always_comb begin
    if (ang_ext >= DEG_HALF) begin
      red_nxt = ang_ext - DEG_FULL;
    end else if (ang_ext < -DEG_HALF) begin
      red_nxt = ang_ext + DEG_FULL;
    end else begin
      red_nxt = ang_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      red_r <= red_nxt;
    end
  end

  // Fold into [-90, 90] degrees and split off the sign.
  logic signed [ANG_W:0] fold;
  logic                  flip_nxt;
  logic                  neg_nxt;
  logic [MAG_W-1:0]      mag_nxt;
  logic [MAG_W-1:0]      mag_r;
  logic                  neg2_r;
  logic                  flip2_r;
  logic                  v2_r;

  always_comb begin
    flip_nxt = 1'b0;
    fold     = red_r;
    if (red_r > DEG_QUARTER) begin
      fold     = DEG_HALF - red_r;
      flip_nxt = 1'b1;
    end else if (red_r < -DEG_QUARTER) begin
      fold     = -DEG_HALF - red_r;
      flip_nxt = 1'b1;
    end
    neg_nxt = (fold < 0);
    mag_nxt = neg_nxt ? MAG_W'(-fold) : MAG_W'(fold);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag_r   <= mag_nxt;
      neg2_r  <= neg_nxt;
      flip2_r <= flip_nxt;
    end
  end

  // Multiply the magnitude by pi/4.
  logic [PROD_W-1:0] prod_nxt;
  logic [PROD_W-1:0] prod_r;
  logic              neg3_r;
  logic              flip3_r;
  logic              v3_r;

  assign prod_nxt = PROD_W'(mag_r) * PROD_W'(PI4_Q30);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r  <= prod_nxt;
      neg3_r  <= neg2_r;
      flip3_r <= flip2_r;
    end
  end

  // Round and drop the 2^21 factor; the divider then removes the factor 45.
  logic [PROD_W:0]   numer;
  logic [DIV_W-1:0]  dv_num_r  [DIV_ST+1];
  logic [REM_W-1:0]  dv_rem_r  [DIV_ST+1];
  logic [DIV_W-1:0]  dv_quo_r  [DIV_ST+1];
  logic              dv_neg_r  [DIV_ST+1];
  logic              dv_flip_r [DIV_ST+1];
  logic              dv_vld_r  [DIV_ST+1];

  assign numer = (PROD_W + 1)'(prod_r) + (PROD_W + 1)'(RND_HALF);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_vld_r[0] <= 1'b0;
    end else if (en) begin
      dv_vld_r[0] <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_num_r[0]  <= DIV_W'(numer >> DEG_FRAC);
      dv_rem_r[0]  <= '0;
      dv_quo_r[0]  <= '0;
      dv_neg_r[0]  <= neg3_r;
      dv_flip_r[0] <= flip3_r;
    end
  end

  // Long division by 45, a byte of quotient per stage.
  for (genvar d = 0; d < DIV_ST; d++) begin : g_div
    logic [DIV_W-1:0] num;
    logic [DIV_W-1:0] quo;
    logic [REM_W-1:0] rem;
    logic [REM_W:0]   trial;

    always_comb begin
      num   = dv_num_r[d];
      rem   = dv_rem_r[d];
      quo   = dv_quo_r[d];
      trial = '0;
      for (int b = 0; b < DIV_BITS; b++) begin
        trial = {rem, num[DIV_W-1]};
        num   = {num[DIV_W-2:0], 1'b0};
        if (trial >= DIV_BASE) begin
          rem = REM_W'(trial - DIV_BASE);
          quo = {quo[DIV_W-2:0], 1'b1};
        end else begin
          rem = trial[REM_W-1:0];
          quo = {quo[DIV_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_vld_r[d+1] <= 1'b0;
      end else if (en) begin
        dv_vld_r[d+1] <= dv_vld_r[d];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_num_r[d+1]  <= num;
        dv_rem_r[d+1]  <= rem;
        dv_quo_r[d+1]  <= quo;
        dv_neg_r[d+1]  <= dv_neg_r[d];
        dv_flip_r[d+1] <= dv_flip_r[d];
      end
    end
  end

  // Signed radians start the rotation.
  logic signed [CW-1:0] rad_s;
  logic signed [CW-1:0] cx_r [STAGES+1];
  logic signed [CW-1:0] cy_r [STAGES+1];
  logic signed [CW-1:0] cz_r [STAGES+1];
  logic                 cf_r [STAGES+1];
  logic                 cv_r [STAGES+1];

  assign rad_s = $signed(CW'(dv_quo_r[DIV_ST][ANGLE_W-1:0]));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cv_r[0] <= 1'b0;
    end else if (en) begin
      cv_r[0] <= dv_vld_r[DIV_ST];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cx_r[0] <= CORDIC_GAIN;
      cy_r[0] <= '0;
      cz_r[0] <= dv_neg_r[DIV_ST] ? -rad_s : rad_s;
      cf_r[0] <= dv_flip_r[DIV_ST];
    end
  end

  // Rotation CORDIC, one iteration per stage.
  for (genvar i = 0; i < STAGES; i++) begin : g_rot
    localparam logic signed [CW-1:0] AT_I = CW'(ATAN_TAB[i]);
    logic signed [CW-1:0] nx;
    logic signed [CW-1:0] ny;
    logic signed [CW-1:0] nz;

    always_comb begin
      if (cz_r[i] >= 0) begin
        nx = cx_r[i] - (cy_r[i] >>> i);
        ny = cy_r[i] + (cx_r[i] >>> i);
        nz = cz_r[i] - AT_I;
      end else begin
        nx = cx_r[i] + (cy_r[i] >>> i);
        ny = cy_r[i] - (cx_r[i] >>> i);
        nz = cz_r[i] + AT_I;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        cv_r[i+1] <= 1'b0;
      end else if (en) begin
        cv_r[i+1] <= cv_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        cx_r[i+1] <= nx;
        cy_r[i+1] <= ny;
        cz_r[i+1] <= nz;
        cf_r[i+1] <= cf_r[i];
      end
    end
  end

  // Undo the fold on the cosine and clamp both results.
  logic signed [CW-1:0]     cos_raw;
  logic signed [TRIG_W-1:0] sin_r;
  logic signed [TRIG_W-1:0] cos_r;
  logic                     vo_r;

  assign cos_raw = cf_r[STAGES] ? -cx_r[STAGES] : cx_r[STAGES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else if (en) begin
      vo_r <= cv_r[STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sin_r <= clamp_unit(cy_r[STAGES]);
      cos_r <= clamp_unit(cos_raw);
    end
  end

  assign vld_o = vo_r;
  assign sin_o = sin_r;
  assign cos_o = cos_r;

endmodule

FILE: rtl/core/hdu_asin.sv
// Pipelined central angle 2*asin(sqrt(a)) / 2 = asin(sqrt(a)) in Q30 radians.
// Two bit-per-stage square roots, then a vectoring CORDIC for atan2(h, sqrt(1-h^2)).
// Depends on hdu_pkg.
module hdu_asin
  import hdu_pkg::*;
#(
  parameter int STAGES = CORDIC_STAGES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               vld_i,
  input  logic [HV_W-1:0]    hv_i,
  output logic               vld_o,
  output logic [ANGLE_W-1:0] ang_o
);

  // First root: h = sqrt(a) in Q30.
  sqrt_t s1_r  [ROOT_W+1];
  logic  s1v_r [ROOT_W+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1v_r[0] <= 1'b0;
    end else if (en) begin
      s1v_r[0] <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r[0] <= '{rem: SQ_W'(hv_i) << 30, root: '0};
    end
  end

  for (genvar j = 0; j < ROOT_W; j++) begin : g_sq1
    localparam int K = ROOT_W - 1 - j;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        s1v_r[j+1] <= 1'b0;
      end else if (en) begin
        s1v_r[j+1] <= s1v_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        s1_r[j+1] <= sqrt_step(s1_r[j], K);
      end
    end
  end

  // Square h for the complementary leg.
  logic [ROOT_W-1:0] h;
  logic [ROOT_W-1:0] h_r;
  logic [SQ_W-1:0]   hsq_r;
  logic              hv_r;

  assign h = s1_r[ROOT_W].root;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hv_r <= 1'b0;
    end else if (en) begin
      hv_r <= s1v_r[ROOT_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h_r   <= h;
      hsq_r <= SQ_W'(h) * SQ_W'(h);
    end
  end

  // Second root: c = sqrt(1 - h^2), with h carried alongside.
  sqrt_t             s2_r  [ROOT_W+1];
  logic [ROOT_W-1:0] s2h_r [ROOT_W+1];
  logic              s2v_r [ROOT_W+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2v_r[0] <= 1'b0;
    end else if (en) begin
      s2v_r[0] <= hv_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_r[0]  <= '{rem: ONE_Q60 - hsq_r, root: '0};
      s2h_r[0] <= h_r;
    end
  end

  for (genvar j = 0; j < ROOT_W; j++) begin : g_sq2
    localparam int K = ROOT_W - 1 - j;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        s2v_r[j+1] <= 1'b0;
      end else if (en) begin
        s2v_r[j+1] <= s2v_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        s2_r[j+1]  <= sqrt_step(s2_r[j], K);
        s2h_r[j+1] <= s2h_r[j];
      end
    end
  end

  // Vectoring CORDIC starts from (c, h) with zero angle.
  logic signed [CW-1:0] vx_r [STAGES+1];
  logic signed [CW-1:0] vy_r [STAGES+1];
  logic signed [CW-1:0] vz_r [STAGES+1];
  logic                 vv_r [STAGES+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vv_r[0] <= 1'b0;
    end else if (en) begin
      vv_r[0] <= s2v_r[ROOT_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vx_r[0] <= $signed(CW'(s2_r[ROOT_W].root));
      vy_r[0] <= $signed(CW'(s2h_r[ROOT_W]));
      vz_r[0] <= '0;
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_vec
    localparam logic signed [CW-1:0] AT_I = CW'(ATAN_TAB[i]);
    logic signed [CW-1:0] nx;
    logic signed [CW-1:0] ny;
    logic signed [CW-1:0] nz;

    always_comb begin
      if (vy_r[i] < 0) begin
        nx = vx_r[i] - (vy_r[i] >>> i);
        ny = vy_r[i] + (vx_r[i] >>> i);
        nz = vz_r[i] - AT_I;
      end else begin
        nx = vx_r[i] + (vy_r[i] >>> i);
        ny = vy_r[i] - (vx_r[i] >>> i);
        nz = vz_r[i] + AT_I;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vv_r[i+1] <= 1'b0;
      end else if (en) begin
        vv_r[i+1] <= vv_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        vx_r[i+1] <= nx;
        vy_r[i+1] <= ny;
        vz_r[i+1] <= nz;
      end
    end
  end

  // Negative residual angles clamp to zero.
  logic [ANGLE_W-1:0] ang_r;
  logic               vo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else if (en) begin
      vo_r <= vv_r[STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ang_r <= (vz_r[STAGES] < 0) ? '0 : ANGLE_W'(vz_r[STAGES]);
    end
  end

  assign vld_o = vo_r;
  assign ang_o = ang_r;

endmodule

FILE: rtl/core/haversine_distance_unit.sv
// Top level of the haversine great-circle distance unit.
// Instantiates four hdu_sincos pipelines and one hdu_asin pipeline; depends on hdu_pkg.
//
//   Channel  Direction  Handshake              Payload
//   in_      request    in_valid / in_ready    two points, degrees Q20 signed
//   out_     result     out_valid / out_ready  distance, radius units Q8
//   cfg_     write      cfg_wr_en              earth_radius, 13 bits
//
// One request enters per cycle while the pipeline is not held; each result passes
// through the two CORDIC chains and the two bit-per-stage square roots in series.
// Reset clears every valid bit and loads the radius with 6371.
// When the output register is full and not taken, the whole pipeline holds.
module haversine_distance_unit
  import hdu_pkg::*;
#(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [RADIUS_W-1:0]        cfg_wr_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [LAT_W-1:0]    in_first_latitude,
  input  logic signed [LON_W-1:0]    in_first_longitude,
  input  logic signed [LAT_W-1:0]    in_second_latitude,
  input  logic signed [LON_W-1:0]    in_second_longitude,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [DIST_W-1:0]          out_distance
);

  // Pipeline advance: the output register is free or being emptied.
  logic adv;
  logic out_valid_r;

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  // Radius register.
  logic [RADIUS_W-1:0] earth_radius_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      earth_radius_r <= RADIUS_RST;
    end else if (cfg_wr_en) begin
      earth_radius_r <= cfg_wr_data;
    end
  end

  // Half differences and full latitudes in degrees Q21.
  logic signed [ANG_W-1:0] dlat_r;
  logic signed [ANG_W-1:0] dlon_r;
  logic signed [ANG_W-1:0] lat1_r;
  logic signed [ANG_W-1:0] lat2_r;
  logic                    a_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (adv) begin
      a_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dlat_r <= ANG_W'(in_second_latitude) - ANG_W'(in_first_latitude);
      dlon_r <= ANG_W'(in_second_longitude) - ANG_W'(in_first_longitude);
      lat1_r <= ANG_W'(in_first_latitude) <<< 1;
      lat2_r <= ANG_W'(in_second_latitude) <<< 1;
    end
  end

  // Trigonometric terms.
  logic                     sc_vld;
  logic signed [TRIG_W-1:0] s_lat;
  logic signed [TRIG_W-1:0] s_lon;
  logic signed [TRIG_W-1:0] c_a;
  logic signed [TRIG_W-1:0] c_b;

  hdu_sincos #(.STAGES(CORDIC_STAGES)) u_sc_dlat (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (adv),
    .vld_i (a_vld_r),
    .ang_i (dlat_r),
    .vld_o (sc_vld),
    .sin_o (s_lat),
    .cos_o ()
  );

  hdu_sincos #(.STAGES(CORDIC_STAGES)) u_sc_dlon (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (adv),
    .vld_i (a_vld_r),
    .ang_i (dlon_r),
    .vld_o (),
    .sin_o (s_lon),
    .cos_o ()
  );

  hdu_sincos #(.STAGES(CORDIC_STAGES)) u_sc_lat1 (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (adv),
    .vld_i (a_vld_r),
    .ang_i (lat1_r),
    .vld_o (),
    .sin_o (),
    .cos_o (c_a)
  );

  hdu_sincos #(.STAGES(CORDIC_STAGES)) u_sc_lat2 (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (adv),
    .vld_i (a_vld_r),
    .ang_i (lat2_r),
    .vld_o (),
    .sin_o (),
    .cos_o (c_b)
  );

  // Squares of the sines and the cosine product, back to Q30.
  logic signed [2*TRIG_W-1:0] sq_lat;
  logic signed [2*TRIG_W-1:0] sq_lon;
  logic signed [2*TRIG_W-1:0] cc_prod;
  logic signed [PW-1:0]       sl2_r;
  logic signed [PW-1:0]       sn2_r;
  logic signed [PW-1:0]       pc_r;
  logic                       p1_vld_r;

  assign sq_lat  = s_lat * s_lat;
  assign sq_lon  = s_lon * s_lon;
  assign cc_prod = c_a * c_b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
    end else if (adv) begin
      p1_vld_r <= sc_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sl2_r <= PW'(sq_lat >>> 30);
      sn2_r <= PW'(sq_lon >>> 30);
      pc_r  <= PW'(cc_prod >>> 30);
    end
  end

  // Longitude term weighted by the cosines.
  logic signed [2*PW-1:0] term_prod;
  logic signed [PW-1:0]   term_r;
  logic signed [PW-1:0]   sl2b_r;
  logic                   p2_vld_r;

  assign term_prod = pc_r * sn2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2_vld_r <= 1'b0;
    end else if (adv) begin
      p2_vld_r <= p1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      term_r <= PW'(term_prod >>> 30);
      sl2b_r <= sl2_r;
    end
  end

  // Haversine value a, clamped to [0, 1].
  logic signed [PW:0]  hv_sum;
  logic [HV_W-1:0]     hv_nxt;
  logic [HV_W-1:0]     hv_r;
  logic                p3_vld_r;

  assign hv_sum = (PW + 1)'(sl2b_r) + (PW + 1)'(term_r);

  always_comb begin
    if (hv_sum < 0) begin
      hv_nxt = '0;
    end else if (hv_sum > (PW + 1)'(ONE_Q30)) begin
      hv_nxt = HV_W'(ONE_Q30);
    end else begin
      hv_nxt = HV_W'(hv_sum);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p3_vld_r <= 1'b0;
    end else if (adv) begin
      p3_vld_r <= p2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hv_r <= hv_nxt;
    end
  end

  // Central angle.
  logic               as_vld;
  logic [ANGLE_W-1:0] as_ang;

  hdu_asin #(.STAGES(CORDIC_STAGES)) u_asin (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (adv),
    .vld_i (p3_vld_r),
    .hv_i  (hv_r),
    .vld_o (as_vld),
    .ang_o (as_ang)
  );

  // Scale by the radius.
  localparam int RP_W = ANGLE_W + RADIUS_W;
  logic [RP_W-1:0] rprod_r;
  logic            m_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r <= 1'b0;
    end else if (adv) begin
      m_vld_r <= as_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rprod_r <= RP_W'(as_ang) * RP_W'(earth_radius_r);
    end
  end

  // Double, round to Q8 and saturate into the output register.
  logic [RP_W+1:0]   dsum;
  logic [DIST_W:0]   dq;
  logic [DIST_W-1:0] dist_nxt;
  logic [DIST_W-1:0] dist_r;

  assign dsum     = {1'b0, rprod_r, 1'b0} + (RP_W + 2)'(1 << 21);
  assign dq       = dsum[RP_W+1:22];
  assign dist_nxt = dq[DIST_W] ? '1 : dq[DIST_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= m_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dist_r <= dist_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_distance = dist_r;

endmodule
